// ===== design/ptws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptws_pkg
// Shared types and constants of the prescaled timer with timestamp slots.
// ----------------------------------------------------------------------------
package ptws_pkg;

  localparam int STAMP_SLOTS = 2;
  localparam int CHANNELS    = 4;
  localparam int CMP_REGS    = 4;

  localparam int StampIdxW = (STAMP_SLOTS > 1) ? $clog2(STAMP_SLOTS) : 1;

  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_SET_STAMP  = 3'd1;
  localparam logic [2:0] OP_GET_STAMP  = 3'd2;
  localparam logic [2:0] OP_CLR_STAMP  = 3'd3;
  localparam logic [2:0] OP_CLR_FLAG   = 3'd4;

  localparam logic [2:0] REG_PRESCALE  = 3'd0;
  localparam logic [2:0] REG_ENABLE    = 3'd1;
  localparam logic [2:0] REG_FREEZE    = 3'd2;
  localparam logic [2:0] REG_CHAN_MASK = 3'd3;
  localparam logic [2:0] REG_CMP0      = 3'd4;
  localparam logic [2:0] REG_CMP1      = 3'd5;
  localparam logic [2:0] REG_CMP2      = 3'd6;
  localparam logic [2:0] REG_CMP3      = 3'd7;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] stamp_index;
    logic [1:0] channel_index;
    logic       debug_halt;
  } cmd_t;

  typedef struct packed {
    logic [31:0] elapsed_ticks;
    logic        elapsed_valid;
    logic [3:0]  match_flags;
    logic [31:0] counter_now;
  } res_t;

endpackage

// ===== design/prescaled_timer_with_stamps_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prescaled_timer_with_stamps_core
// 32-bit timer advanced by tick commands, with prescaler, compare flags and timestamp slots.
// ----------------------------------------------------------------------------
// One command per cycle while not stalled. Each accepted command updates the
// timer state in the cycle it is taken and its result lands in the output
// register on the same edge, giving one transaction per clock without stalls.
// The command side stalls only while the output register is full and its
// receiver stalls. Configuration writes are taken on any cycle with cfg_we.
module prescaled_timer_with_stamps_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  ptws_pkg::cmd_t      cmd,
  output logic                res_valid,
  input  logic                res_stall,
  output ptws_pkg::res_t      res,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam logic [3:0] ChanMask = 4'((1 << ptws_pkg::CHANNELS) - 1);
  localparam logic [2:0] SlotLim  = 3'(ptws_pkg::STAMP_SLOTS);
  localparam logic [2:0] ChanLim  = 3'(ptws_pkg::CHANNELS);

  logic [8:0]  prescale_divide;
  logic        timer_enable;
  logic        freeze_in_debug;
  logic [3:0]  channel_enable_mask;
  logic [31:0] compare_val [ptws_pkg::CMP_REGS];

  logic [31:0] tick_counter, tick_counter_next;
  logic [7:0]  prescale_count, prescale_count_next;
  logic [31:0] stamp_value [ptws_pkg::STAMP_SLOTS];
  logic [31:0] stamp_value_next [ptws_pkg::STAMP_SLOTS];
  logic [ptws_pkg::STAMP_SLOTS-1:0] stamp_set, stamp_set_next;
  logic [3:0]  flag_bits, flag_bits_next;

  logic        accept;
  logic [7:0]  div_m1;
  logic        slot_ok;
  logic        chan_ok;
  logic [ptws_pkg::StampIdxW-1:0] slot;
  logic [31:0] elapsed;
  logic        elapsed_ok;

  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign slot_ok   = {1'b0, cmd.stamp_index} < SlotLim;
  assign chan_ok   = {1'b0, cmd.channel_index} < ChanLim;
  assign slot      = cmd.stamp_index[ptws_pkg::StampIdxW-1:0];

  always_comb begin
    if (prescale_divide == 9'd0) begin
      div_m1 = 8'd0;
    end else if (prescale_divide > 9'd256) begin
      div_m1 = 8'd255;
    end else begin
      div_m1 = 8'(prescale_divide - 9'd1);
    end
  end

  always_comb begin
    tick_counter_next   = tick_counter;
    prescale_count_next = prescale_count;
    stamp_value_next    = stamp_value;
    stamp_set_next      = stamp_set;
    flag_bits_next      = flag_bits;
    elapsed             = 32'd0;
    elapsed_ok          = 1'b0;
    case (cmd.operation)
      ptws_pkg::OP_TICK: begin
        if (timer_enable && !(freeze_in_debug && cmd.debug_halt)) begin
          if (prescale_count >= div_m1) begin
            prescale_count_next = 8'd0;
            tick_counter_next   = tick_counter + 32'd1;
            for (int k = 0; k < ptws_pkg::CMP_REGS; k++) begin
              if (channel_enable_mask[k] && ChanMask[k] &&
                  compare_val[k] == tick_counter_next) begin
                flag_bits_next[k] = 1'b1;
              end
            end
          end else begin
            prescale_count_next = prescale_count + 8'd1;
          end
        end
      end
      ptws_pkg::OP_SET_STAMP: begin
        if (slot_ok) begin
          stamp_value_next[slot] = tick_counter;
          stamp_set_next[slot]   = 1'b1;
        end
      end
      ptws_pkg::OP_GET_STAMP: begin
        if (slot_ok && stamp_set[slot]) begin
          elapsed    = tick_counter - stamp_value[slot];
          elapsed_ok = 1'b1;
        end
      end
      ptws_pkg::OP_CLR_STAMP: begin
        if (slot_ok) begin
          stamp_value_next[slot] = 32'd0;
          stamp_set_next[slot]   = 1'b0;
        end
      end
      ptws_pkg::OP_CLR_FLAG: begin
        if (chan_ok) begin
          flag_bits_next[cmd.channel_index] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_divide     <= 9'd1;
      timer_enable        <= 1'b0;
      freeze_in_debug     <= 1'b0;
      channel_enable_mask <= 4'd0;
      for (int k = 0; k < ptws_pkg::CMP_REGS; k++) begin
        compare_val[k] <= 32'd0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        ptws_pkg::REG_PRESCALE:  prescale_divide     <= cfg_data[8:0];
        ptws_pkg::REG_ENABLE:    timer_enable        <= cfg_data[0];
        ptws_pkg::REG_FREEZE:    freeze_in_debug     <= cfg_data[0];
        ptws_pkg::REG_CHAN_MASK: channel_enable_mask <= cfg_data[3:0];
        ptws_pkg::REG_CMP0:      compare_val[0]      <= cfg_data;
        ptws_pkg::REG_CMP1:      compare_val[1]      <= cfg_data;
        ptws_pkg::REG_CMP2:      compare_val[2]      <= cfg_data;
        ptws_pkg::REG_CMP3:      compare_val[3]      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter   <= 32'd0;
      prescale_count <= 8'd0;
      stamp_set      <= '0;
      flag_bits      <= 4'd0;
      for (int i = 0; i < ptws_pkg::STAMP_SLOTS; i++) begin
        stamp_value[i] <= 32'd0;
      end
    end else if (accept) begin
      tick_counter   <= tick_counter_next;
      prescale_count <= prescale_count_next;
      stamp_set      <= stamp_set_next;
      flag_bits      <= flag_bits_next;
      stamp_value    <= stamp_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.elapsed_ticks <= elapsed;
      res.elapsed_valid <= elapsed_ok;
      res.match_flags   <= flag_bits_next;
      res.counter_now   <= tick_counter_next;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the prescaled timer with timestamp slots.
// A clocked driver feeds commands from a backlog in random bursts, and a
// clocked monitor predicts each accepted transaction with an in-bench timer
// model. It checks every returned result in order while the result side
// stalls on its own pattern. Configuration changes only between phases,
// once the block is drained.
// ----------------------------------------------------------------------------
module tb;
  import ptws_pkg::*;

  localparam int          CYCLE_LIMIT     = 500000;
  localparam int          RANDOM_PHASES   = 10;
  localparam int          PHASE_ITEMS     = 115;
  localparam int          MAX_REPORTS     = 100;
  localparam logic [2:0]  OP_FIRST_UNUSED = OP_CLR_FLAG + 3'd1;

  typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_CHOKED} flow_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd       = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  // timer model state and its copy of the registers
  logic [31:0] tick_count;
  logic [7:0]  pre_count;
  logic [31:0] stamp_val [STAMP_SLOTS];
  logic        stamp_ok  [STAMP_SLOTS];
  logic [3:0]  hit_flags;
  logic [8:0]  cfg_divide;
  logic        cfg_enable;
  logic        cfg_freeze;
  logic [3:0]  cfg_chan_mask;
  logic [31:0] cfg_cmp [CMP_REGS];

  cmd_t cmd_backlog [$];
  res_t res_due [$];
  logic cmd_took = 1'b0;
  int   errors = 0;
  int   cycles = 0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   flow_left = 0;
  flow_t flow = FLOW_FREE;

  prescaled_timer_with_stamps_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void timer_clear();
    tick_count    = '0;
    pre_count     = '0;
    hit_flags     = '0;
    cfg_divide    = 9'd1;
    cfg_enable    = 1'b0;
    cfg_freeze    = 1'b0;
    cfg_chan_mask = '0;
    for (int i = 0; i < STAMP_SLOTS; i++) begin
      stamp_val[i] = '0;
      stamp_ok[i]  = 1'b0;
    end
    for (int i = 0; i < CMP_REGS; i++) cfg_cmp[i] = '0;
  endfunction

  function automatic res_t timer_step(cmd_t c);
    res_t       r;
    logic [7:0] wrap_at;
    logic [StampIdxW-1:0] si;
    r = '0;
    si = c.stamp_index[StampIdxW-1:0];
    case (c.operation)
      OP_TICK: begin
        if (cfg_enable && !(cfg_freeze && c.debug_halt)) begin
          if (cfg_divide == 9'd0) wrap_at = 8'd0;
          else if (cfg_divide > 9'd256) wrap_at = 8'd255;
          else wrap_at = 8'(cfg_divide - 9'd1);
          if (pre_count >= wrap_at) begin
            pre_count  = '0;
            tick_count = tick_count + 32'd1;
            for (int k = 0; k < CHANNELS; k++)
              if (cfg_chan_mask[k] && cfg_cmp[k] == tick_count) hit_flags[k] = 1'b1;
          end else begin
            pre_count = pre_count + 8'd1;
          end
        end
      end
      OP_SET_STAMP: begin
        if (int'(c.stamp_index) < STAMP_SLOTS) begin
          stamp_val[si] = tick_count;
          stamp_ok[si]  = 1'b1;
        end
      end
      OP_GET_STAMP: begin
        if (int'(c.stamp_index) < STAMP_SLOTS && stamp_ok[si]) begin
          r.elapsed_ticks = tick_count - stamp_val[si];
          r.elapsed_valid = 1'b1;
        end
      end
      OP_CLR_STAMP: begin
        if (int'(c.stamp_index) < STAMP_SLOTS) begin
          stamp_val[si] = '0;
          stamp_ok[si]  = 1'b0;
        end
      end
      OP_CLR_FLAG: begin
        if (int'(c.channel_index) < CHANNELS) hit_flags[c.channel_index] = 1'b0;
      end
      default: ;
    endcase
    r.match_flags = hit_flags;
    r.counter_now = tick_count;
    return r;
  endfunction

  task automatic report_field(string what, logic [31:0] want, logic [31:0] got);
    if (errors < MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    errors++;
  endtask

  // monitor: check returned results, then predict the newly accepted command
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      cmd_took = 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (res_due.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual %h", $time, res);
          errors++;
        end else begin
          want = res_due.pop_front();
          if (res.elapsed_ticks !== want.elapsed_ticks)
            report_field("elapsed_ticks", want.elapsed_ticks, res.elapsed_ticks);
          if (res.elapsed_valid !== want.elapsed_valid)
            report_field("elapsed_valid", 32'(want.elapsed_valid), 32'(res.elapsed_valid));
          if (res.match_flags !== want.match_flags)
            report_field("match_flags", 32'(want.match_flags), 32'(res.match_flags));
          if (res.counter_now !== want.counter_now)
            report_field("counter_now", want.counter_now, res.counter_now);
        end
      end
      cmd_took = cmd_valid && !cmd_stall;
      if (cmd_took) res_due.push_back(timer_step(cmd));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // driver: bursts of commands separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_took) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cmd       <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(24, 1);
          gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, changing its character whenever flow_left runs out
  always @(negedge clk) begin
    if (flow_left == 0) begin
      flow      = flow_t'($urandom_range(3, 0));
      flow_left = $urandom_range(64, 8);
    end else begin
      flow_left--;
    end
    case (flow)
      FLOW_FREE:  res_stall <= 1'b0;
      FLOW_LIGHT: res_stall <= ($urandom_range(3, 0) == 0);
      FLOW_HEAVY: res_stall <= ($urandom_range(9, 0) < 6);
      default:    res_stall <= ($urandom_range(15, 0) != 0);
    endcase
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || res_due.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PRESCALE:  cfg_divide    = val[8:0];
      REG_ENABLE:    cfg_enable    = val[0];
      REG_FREEZE:    cfg_freeze    = val[0];
      REG_CHAN_MASK: cfg_chan_mask = val[3:0];
      default:       cfg_cmp[2'(idx - REG_CMP0)] = val;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(logic [8:0] divide, logic en, logic frz, logic [3:0] mask,
                           logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                           logic [31:0] c3);
    write_reg(REG_PRESCALE, 32'(divide));
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_FREEZE, 32'(frz));
    write_reg(REG_CHAN_MASK, 32'(mask));
    write_reg(REG_CMP0, c0);
    write_reg(REG_CMP1, c1);
    write_reg(REG_CMP2, c2);
    write_reg(REG_CMP3, c3);
    cfg_we <= 1'b0;
  endtask

  task automatic push_cmd(logic [2:0] op, logic [1:0] slot, logic [1:0] chan, logic halt);
    cmd_t c;
    c.operation     = op;
    c.stamp_index   = slot;
    c.channel_index = chan;
    c.debug_halt    = halt;
    cmd_backlog.push_back(c);
  endtask

  function automatic logic [31:0] pick_compare();
    case ($urandom_range(9, 0))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return tick_count + 32'($urandom_range(40, 1));
    endcase
  endfunction

  task automatic queue_random(int n);
    int          pick;
    logic [2:0]  op;
    logic [1:0]  slot;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 45) op = OP_TICK;
      else if (pick < 57) op = OP_SET_STAMP;
      else if (pick < 75) op = OP_GET_STAMP;
      else if (pick < 82) op = OP_CLR_STAMP;
      else if (pick < 95) op = OP_CLR_FLAG;
      else op = 3'($urandom_range(7, OP_FIRST_UNUSED));
      // keep most slot accesses in range, where the stamps live
      slot = ($urandom_range(4, 0) == 0) ? 2'($urandom_range(3, 0))
                                         : 2'($urandom_range(STAMP_SLOTS - 1, 0));
      push_cmd(op, slot, 2'($urandom_range(3, 0)), ($urandom_range(9, 0) < 3));
    end
  endtask

  initial begin
    logic [2:0]  unused_op;
    logic [8:0]  divide;
    logic [31:0] cmp [CMP_REGS];
    timer_clear();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    wait_drained();

    // directed: prescale zero acts as one, freeze on, all channels armed
    write_all(9'd0, 1'b1, 1'b1, 4'hF, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'd3);
    push_cmd(OP_GET_STAMP, 2'd0, 2'd0, 1'b0);
    push_cmd(OP_SET_STAMP, 2'd0, 2'd0, 1'b0);
    push_cmd(OP_TICK, 2'd0, 2'd0, 1'b0);
    push_cmd(OP_TICK, 2'd0, 2'd0, 1'b1);
    push_cmd(OP_TICK, 2'd3, 2'd3, 1'b0);
    push_cmd(OP_GET_STAMP, 2'd0, 2'd0, 1'b0);
    push_cmd(OP_SET_STAMP, 2'd2, 2'd0, 1'b0);
    push_cmd(OP_GET_STAMP, 2'd3, 2'd0, 1'b0);
    push_cmd(OP_CLR_STAMP, 2'd3, 2'd0, 1'b0);
    push_cmd(OP_CLR_FLAG, 2'd0, 2'd0, 1'b0);
    push_cmd(OP_SET_STAMP, 2'd1, 2'd0, 1'b1);
    push_cmd(OP_TICK, 2'd0, 2'd0, 1'b0);
    push_cmd(OP_GET_STAMP, 2'd1, 2'd0, 1'b0);
    push_cmd(OP_CLR_STAMP, 2'd0, 2'd0, 1'b0);
    push_cmd(OP_GET_STAMP, 2'd0, 2'd0, 1'b0);
    unused_op = OP_FIRST_UNUSED;
    repeat (3) begin
      push_cmd(unused_op, 2'd3, 2'd3, 1'b1);
      unused_op++;
    end
    push_cmd(OP_CLR_FLAG, 2'd0, 2'd3, 1'b0);
    wait_drained();

    // oversized prescale saturates at 256; halt ignored with freeze off
    write_all(9'd511, 1'b1, 1'b0, 4'hF, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'd5);
    repeat (3) push_cmd(OP_TICK, 2'd0, 2'd0, 1'b1);
    wait_drained();

    // divide lowered below the running prescale count: next tick wraps
    write_all(9'd2, 1'b1, 1'b0, 4'hF, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'd5);
    repeat (2) push_cmd(OP_TICK, 2'd0, 2'd0, 1'b0);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(9, 0))
        0:       divide = 9'd0;
        1:       divide = 9'd256;
        2:       divide = 9'($urandom_range(511, 257));
        default: divide = 9'($urandom_range(4, 1));
      endcase
      if (p == 0) divide = 9'd256;
      if (p == 1) divide = 9'd1;
      for (int k = 0; k < CMP_REGS; k++) cmp[k] = pick_compare();
      write_all(divide, ($urandom_range(9, 0) != 0), 1'($urandom_range(1, 0)),
                (p == 1) ? 4'hF : 4'($urandom_range(15, 0)),
                cmp[0], cmp[1], cmp[2], cmp[3]);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (4) @(negedge clk);
    if (errors == 0 && res_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
